[rtl/core/ugtm_pkg.sv]
// Shared types and constants for the UTF-8 glyph tile mapper.
// No dependencies; every block file refers to it by scoped names.
`timescale 1ns / 1ps

package ugtm_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int SIZE_W      = 9;
  localparam int BYTE_W      = 8;
  localparam int CP_W        = 16;
  localparam int ENTRY_W     = CP_W + BYTE_W;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TABLE_SIZE = 2'd0,
    CFG_MAX_LEN    = 2'd1,
    CFG_FALLBACK   = 2'd2,
    CFG_TERMINATOR = 2'd3
  } cfg_reg_e;

  // Input word command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 9'd0;
  localparam logic [BYTE_W-1:0] MAX_LEN_RST    = 8'd255;
  localparam logic [BYTE_W-1:0] FALLBACK_RST   = 8'd186;
  localparam logic [BYTE_W-1:0] TERMINATOR_RST = 8'd255;

  // UTF-8 byte classes
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
  localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

  // Controller to datapath
  typedef struct packed {
    logic wr_entry;      // store one table entry
    logic take_byte;     // decode one text byte
    logic start_search;  // set up bounds, issue first probe
    logic step_search;   // compare probe, narrow bounds
    logic emit_search;   // push the search result out
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;            // output register can load this cycle
    logic byte_starts_search;  // current byte completes a code point
    logic probe_hit;           // probed key equals the code point
    logic probe_go;            // bounds still span at least one entry
  } status_t;

endpackage

[rtl/core/ugtm_ctrl.sv]
// Sequencer of the glyph tile mapper: handshake and search control.
// Depends on ugtm_pkg for the command and status structs.
`timescale 1ns / 1ps

module ugtm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              command_i,
  output logic              in_stall_o,
  input  ugtm_pkg::status_t status_i,
  output ugtm_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = !((state_q == ST_IDLE) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == ugtm_pkg::CMD_LOAD) begin
            cmd_o.wr_entry = 1'b1;
          end else begin
            cmd_o.take_byte = 1'b1;
            if (status_i.byte_starts_search) begin
              state_d = ST_START;
            end
          end
        end
      end
      ST_START: begin
        cmd_o.start_search = 1'b1;
        state_d = status_i.probe_go ? ST_PROBE : ST_EMIT;
      end
      ST_PROBE: begin
        cmd_o.step_search = 1'b1;
        if (status_i.probe_hit || !status_i.probe_go) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_search = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/ugtm_dp.sv]
// Datapath of the glyph tile mapper: config, UTF-8 decode, table, search, output.
// Depends on ugtm_pkg; driven by ugtm_ctrl through cmd_t and status_t.
`timescale 1ns / 1ps

module ugtm_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ugtm_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [ugtm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [ugtm_pkg::BYTE_W-1:0]          entry_index_i,
  input  logic [ugtm_pkg::CP_W-1:0]            entry_code_point_i,
  input  logic [ugtm_pkg::BYTE_W-1:0]          entry_tile_i,
  input  logic [ugtm_pkg::BYTE_W-1:0]          text_byte_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [ugtm_pkg::BYTE_W-1:0]          tile_o,
  output logic                                 is_terminator_o,
  output logic [ugtm_pkg::BYTE_W-1:0]          string_length_o,
  input  ugtm_pkg::cmd_t                       cmd_i,
  output ugtm_pkg::status_t                    status_o
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int NW0 = (CW > ugtm_pkg::SIZE_W) ? CW : ugtm_pkg::SIZE_W;
  localparam int NW  = (NW0 > ugtm_pkg::BYTE_W) ? NW0 : ugtm_pkg::BYTE_W;

  // Configuration
  logic [ugtm_pkg::SIZE_W-1:0] table_size_q;
  logic [ugtm_pkg::BYTE_W-1:0] max_len_q, fallback_q, terminator_q;

  // String state
  logic [1:0]                  pending_q;
  logic [ugtm_pkg::CP_W-1:0]   partial_q;
  logic [ugtm_pkg::BYTE_W-1:0] tiles_q;

  // Search state
  logic [ugtm_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ugtm_pkg::ENTRY_W-1:0] rdata_q;
  logic [ugtm_pkg::CP_W-1:0]    cp_q;
  logic [CW-1:0]                lo_q, hi_q;
  logic [AW-1:0]                mid_q;
  logic [ugtm_pkg::BYTE_W-1:0]  res_q;

  // Output register
  logic                        out_valid_q;
  logic [ugtm_pkg::BYTE_W-1:0] tile_q, len_q;
  logic                        term_q;

  // Byte decode
  logic                        is_nul, pend, last, full, ascii, lead2, lead3;
  logic [ugtm_pkg::BYTE_W-1:0] limit;
  logic [ugtm_pkg::CP_W-1:0]   cp_next;
  logic                        emit_byte, emit_any;
  logic [ugtm_pkg::BYTE_W-1:0] tiles_inc;

  assign is_nul  = (text_byte_i == '0);
  assign pend    = (pending_q != 2'd0);
  assign last    = (pending_q == 2'd1);
  assign cp_next = {partial_q[ugtm_pkg::CP_W-7:0], text_byte_i[5:0] & ugtm_pkg::CONT_BITS[5:0]};
  assign limit   = (max_len_q == '0) ? '0 : max_len_q - 1'b1;
  assign full    = (tiles_q >= limit);
  assign ascii   = (text_byte_i < ugtm_pkg::ASCII_LIMIT);
  assign lead2   = ((text_byte_i & ugtm_pkg::LEAD2_MASK) == ugtm_pkg::LEAD2_CODE);
  assign lead3   = ((text_byte_i & ugtm_pkg::LEAD3_MASK) == ugtm_pkg::LEAD3_CODE);

  assign emit_byte = cmd_i.take_byte && !is_nul && !pend && !full && ascii;
  assign emit_any  = emit_byte || cmd_i.emit_search;
  assign tiles_inc = tiles_q + 1'b1;

  // Search bounds: hi is exclusive, so the range is live while lo < hi
  logic [NW-1:0]        size_w, n_w;
  logic [CW-1:0]        n;
  logic [ugtm_pkg::CP_W-1:0] key;
  logic                 hit, less, go;
  logic [CW-1:0]        lo_n, hi_n, lo_sel, hi_sel, mid_wide;
  logic [CW:0]          mid_sum;
  logic [AW-1:0]        mid_sel;
  logic                 rd_en, idx_ok;

  assign size_w   = NW'(table_size_q);
  assign n_w      = (size_w > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : size_w;
  assign n        = n_w[CW-1:0];
  assign key      = rdata_q[ugtm_pkg::ENTRY_W-1:ugtm_pkg::BYTE_W];
  assign hit      = (key == cp_q);
  assign less     = (key < cp_q);
  assign lo_n     = less ? CW'(mid_q) + 1'b1 : lo_q;
  assign hi_n     = less ? hi_q : CW'(mid_q);
  assign lo_sel   = cmd_i.start_search ? '0 : lo_n;
  assign hi_sel   = cmd_i.start_search ? n : hi_n;
  assign go       = (lo_sel < hi_sel);
  assign mid_sum  = {1'b0, lo_sel} + {1'b0, hi_sel} - 1'b1;
  assign mid_wide = mid_sum[CW:1];
  assign mid_sel  = mid_wide[AW-1:0];
  assign rd_en    = go && (cmd_i.start_search || (cmd_i.step_search && !hit));
  assign idx_ok   = (NW'(entry_index_i) < NW'(TABLE_DEPTH));

  assign status_o.out_free           = !out_valid_q || !out_stall_i;
  assign status_o.byte_starts_search = !is_nul && last;
  assign status_o.probe_hit          = hit;
  assign status_o.probe_go           = go;

  // Table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry && idx_ok) begin
      mem[AW'(entry_index_i)] <= {entry_code_point_i, entry_tile_i};
    end
    if (rd_en) begin
      rdata_q <= mem[mid_sel];
    end
  end

  // Control state, configuration and string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= ugtm_pkg::TABLE_SIZE_RST;
      max_len_q    <= ugtm_pkg::MAX_LEN_RST;
      fallback_q   <= ugtm_pkg::FALLBACK_RST;
      terminator_q <= ugtm_pkg::TERMINATOR_RST;
      pending_q    <= 2'd0;
      partial_q    <= '0;
      tiles_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (ugtm_pkg::cfg_reg_e'(cfg_index_i))
          ugtm_pkg::CFG_TABLE_SIZE: table_size_q <= cfg_data_i;
          ugtm_pkg::CFG_MAX_LEN:    max_len_q    <= cfg_data_i[ugtm_pkg::BYTE_W-1:0];
          ugtm_pkg::CFG_FALLBACK:   fallback_q   <= cfg_data_i[ugtm_pkg::BYTE_W-1:0];
          ugtm_pkg::CFG_TERMINATOR: terminator_q <= cfg_data_i[ugtm_pkg::BYTE_W-1:0];
          default: ;
        endcase
      end

      out_valid_q <= (cmd_i.take_byte && is_nul) || emit_any || (out_valid_q && out_stall_i);

      if (emit_any) begin
        tiles_q <= tiles_inc;
      end

      if (cmd_i.take_byte) begin
        priority if (is_nul) begin
          tiles_q   <= '0;
          pending_q <= 2'd0;
          partial_q <= '0;
        end else if (pend) begin
          pending_q <= pending_q - 2'd1;
          partial_q <= last ? '0 : cp_next;
        end else if (!full) begin
          priority if (ascii) begin
            pending_q <= 2'd0;
          end else if (lead2) begin
            partial_q <= ugtm_pkg::CP_W'(text_byte_i & ugtm_pkg::LEAD2_BITS);
            pending_q <= 2'd1;
          end else if (lead3) begin
            partial_q <= ugtm_pkg::CP_W'(text_byte_i & ugtm_pkg::LEAD3_BITS);
            pending_q <= 2'd2;
          end else begin
            pending_q <= 2'd0;  // stray continuation or long lead: drop
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && pend && last && !is_nul) begin
      cp_q <= cp_next;
    end
    if (cmd_i.start_search || (cmd_i.step_search && !hit)) begin
      lo_q  <= lo_sel;
      hi_q  <= hi_sel;
      mid_q <= mid_sel;
      if (!go) begin
        res_q <= fallback_q;
      end
    end
    if (cmd_i.step_search && hit) begin
      res_q <= rdata_q[ugtm_pkg::BYTE_W-1:0];
    end

    if (cmd_i.take_byte && is_nul) begin
      tile_q <= terminator_q;
      term_q <= 1'b1;
      len_q  <= tiles_q;
    end else if (emit_byte) begin
      tile_q <= text_byte_i;
      term_q <= 1'b0;
      len_q  <= tiles_inc;
    end else if (cmd_i.emit_search) begin
      tile_q <= res_q;
      term_q <= 1'b0;
      len_q  <= tiles_inc;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tile_o          = tile_q;
  assign is_terminator_o = term_q;
  assign string_length_o = len_q;

endmodule

[rtl/core/utf8_glyph_tile_mapper.sv]
// UTF-8 glyph tile mapper, top level. A table load is written at the accepting edge, and an
// ASCII byte or a NUL has its word in the output register right after the accepting edge. The
// last byte of a 2- or 3-byte sequence goes through the accepting cycle, a setup state, the
// probe state and an emit state; a hit ends the probes early. Each probe reads the table
// through the single read port. One word is in flight at a time; a stalled output word holds
// off the input. Reset clears config to defaults and the decoder state; the table memory is
// not cleared until loaded.
`timescale 1ns / 1ps

module utf8_glyph_tile_mapper #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [ugtm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ugtm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [ugtm_pkg::BYTE_W-1:0]      entry_index_i,
  input  logic [ugtm_pkg::CP_W-1:0]        entry_code_point_i,
  input  logic [ugtm_pkg::BYTE_W-1:0]      entry_tile_i,
  input  logic [ugtm_pkg::BYTE_W-1:0]      text_byte_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ugtm_pkg::BYTE_W-1:0]      tile_o,
  output logic                             is_terminator_o,
  output logic [ugtm_pkg::BYTE_W-1:0]      string_length_o
);

  ugtm_pkg::cmd_t    cmd;
  ugtm_pkg::status_t status;

  // Sequencer: takes a word only when idle and the output register can load, so an
  // immediate result never collides with one still waiting downstream.
  ugtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: config registers, byte decoder, code point table, search bounds and the
  // output register that decouples the two channels.
  ugtm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .entry_index_i      (entry_index_i),
    .entry_code_point_i (entry_code_point_i),
    .entry_tile_i       (entry_tile_i),
    .text_byte_i        (text_byte_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .tile_o             (tile_o),
    .is_terminator_o    (is_terminator_o),
    .string_length_o    (string_length_o),
    .cmd_i              (cmd),
    .status_o           (status)
  );

endmodule

[dv/tb_utf8_glyph_tile_mapper.sv]
// Self-checking testbench for utf8_glyph_tile_mapper: table loads and UTF-8 text go in,
// every tile word is predicted and checked field by field. Depends on ugtm_pkg and the RTL.
`timescale 1ns / 1ps

module tb_utf8_glyph_tile_mapper;

  localparam int DEPTH       = 256;
  localparam int HOLD_CYCLES = 300;

  // Predicts the tile words of the mapper and keeps the ones still owed by the block.
  class glyph_scoreboard;
    typedef struct packed {
      logic [ugtm_pkg::BYTE_W-1:0] tile;
      logic                        is_term;
      logic [ugtm_pkg::BYTE_W-1:0] len;
    } glyph_word_t;

    logic [ugtm_pkg::CP_W-1:0]   key_mem  [DEPTH];
    logic [ugtm_pkg::BYTE_W-1:0] tile_mem [DEPTH];
    logic [ugtm_pkg::SIZE_W-1:0] table_size;
    logic [ugtm_pkg::BYTE_W-1:0] max_len;
    logic [ugtm_pkg::BYTE_W-1:0] fallback;
    logic [ugtm_pkg::BYTE_W-1:0] term_code;
    logic [1:0]                  cont_left;
    logic [ugtm_pkg::CP_W-1:0]   partial_cp;
    logic [ugtm_pkg::BYTE_W-1:0] tile_count;
    glyph_word_t                 expected_glyphs[$];
    int                          errors;

    function new();
      foreach (key_mem[i]) begin
        key_mem[i]  = '0;
        tile_mem[i] = '0;
      end
      table_size = ugtm_pkg::TABLE_SIZE_RST;
      max_len    = ugtm_pkg::MAX_LEN_RST;
      fallback   = ugtm_pkg::FALLBACK_RST;
      term_code  = ugtm_pkg::TERMINATOR_RST;
      cont_left  = '0;
      partial_cp = '0;
      tile_count = '0;
      errors     = 0;
    endfunction

    function void set_reg(ugtm_pkg::cfg_reg_e idx, logic [ugtm_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        ugtm_pkg::CFG_TABLE_SIZE: table_size = v;
        ugtm_pkg::CFG_MAX_LEN:    max_len    = v[ugtm_pkg::BYTE_W-1:0];
        ugtm_pkg::CFG_FALLBACK:   fallback   = v[ugtm_pkg::BYTE_W-1:0];
        ugtm_pkg::CFG_TERMINATOR: term_code  = v[ugtm_pkg::BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    // Binary search with mid = (lo + hi) / 2; a size past the depth is clipped.
    function logic [ugtm_pkg::BYTE_W-1:0] search_tile(logic [ugtm_pkg::CP_W-1:0] cp);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = ((table_size > DEPTH) ? DEPTH : int'(table_size)) - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key_mem[mid] == cp) return tile_mem[mid];
        if (key_mem[mid] < cp) lo = mid + 1;
        else hi = mid - 1;
      end
      return fallback;
    endfunction

    function void push_tile(logic [ugtm_pkg::BYTE_W-1:0] t);
      tile_count = tile_count + 8'd1;
      expected_glyphs.push_back('{t, 1'b0, tile_count});
    endfunction

    function void note_word(logic cmd, logic [ugtm_pkg::BYTE_W-1:0] idx,
                            logic [ugtm_pkg::CP_W-1:0] cp,
                            logic [ugtm_pkg::BYTE_W-1:0] tile,
                            logic [ugtm_pkg::BYTE_W-1:0] b);
      logic [ugtm_pkg::BYTE_W-1:0] limit;
      if (cmd == ugtm_pkg::CMD_LOAD) begin
        key_mem[idx]  = cp;
        tile_mem[idx] = tile;
        return;
      end
      // NUL ends the string, also in the middle of a sequence
      if (b == '0) begin
        expected_glyphs.push_back('{term_code, 1'b1, tile_count});
        tile_count = '0;
        cont_left  = '0;
        partial_cp = '0;
        return;
      end
      // any byte counts as a continuation while one is pending
      if (cont_left != '0) begin
        partial_cp = {partial_cp[ugtm_pkg::CP_W-7:0], 6'(b & ugtm_pkg::CONT_BITS)};
        cont_left  = cont_left - 2'd1;
        if (cont_left == '0) begin
          push_tile(search_tile(partial_cp));
          partial_cp = '0;
        end
        return;
      end
      limit = (max_len == '0) ? '0 : max_len - 8'd1;
      if (tile_count >= limit) return;
      if (b < ugtm_pkg::ASCII_LIMIT) begin
        push_tile(b);
      end else if ((b & ugtm_pkg::LEAD2_MASK) == ugtm_pkg::LEAD2_CODE) begin
        partial_cp = ugtm_pkg::CP_W'(b & ugtm_pkg::LEAD2_BITS);
        cont_left  = 2'd1;
      end else if ((b & ugtm_pkg::LEAD3_MASK) == ugtm_pkg::LEAD3_CODE) begin
        partial_cp = ugtm_pkg::CP_W'(b & ugtm_pkg::LEAD3_BITS);
        cont_left  = 2'd2;
      end
    endfunction

    function void check_word(logic [ugtm_pkg::BYTE_W-1:0] tile, logic is_term,
                             logic [ugtm_pkg::BYTE_W-1:0] len);
      glyph_word_t want;
      if (expected_glyphs.size() == 0) begin
        $error("unexpected word: tile %0d is_terminator %0b string_length %0d",
               tile, is_term, len);
        errors++;
        return;
      end
      want = expected_glyphs.pop_front();
      if (tile !== want.tile) begin
        $error("tile: expected %0d, actual %0d", want.tile, tile);
        errors++;
      end
      if (is_term !== want.is_term) begin
        $error("is_terminator: expected %0b, actual %0b", want.is_term, is_term);
        errors++;
      end
      if (len !== want.len) begin
        $error("string_length: expected %0d, actual %0d", want.len, len);
        errors++;
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni             = 1'b0;
  logic                             cfg_we_i           = 1'b0;
  logic [ugtm_pkg::CFG_INDEX_W-1:0] cfg_index_i        = '0;
  logic [ugtm_pkg::CFG_DATA_W-1:0]  cfg_data_i         = '0;
  logic                             in_valid_i         = 1'b0;
  logic                             in_stall_o;
  logic                             command_i          = ugtm_pkg::CMD_TEXT;
  logic [ugtm_pkg::BYTE_W-1:0]      entry_index_i      = '0;
  logic [ugtm_pkg::CP_W-1:0]        entry_code_point_i = '0;
  logic [ugtm_pkg::BYTE_W-1:0]      entry_tile_i       = '0;
  logic [ugtm_pkg::BYTE_W-1:0]      text_byte_i        = '0;
  logic                             out_valid_o;
  logic                             out_stall_i        = 1'b0;
  logic [ugtm_pkg::BYTE_W-1:0]      tile_o;
  logic                             is_terminator_o;
  logic [ugtm_pkg::BYTE_W-1:0]      string_length_o;

  glyph_scoreboard sb = new();

  int idle_pct = 20;         // percent chance of an idle burst per word, 0 turns idling off
  bit hold_req = 1'b0;       // ask the receiver for one long hold-off
  bit slot_written [DEPTH];  // table slots loaded so far; searches stay inside them
  int cur_size = 0;          // entries the search can reach under the current setting

  utf8_glyph_tile_mapper #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .entry_index_i     (entry_index_i),
    .entry_code_point_i(entry_code_point_i),
    .entry_tile_i      (entry_tile_i),
    .text_byte_i       (text_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .tile_o            (tile_o),
    .is_terminator_o   (is_terminator_o),
    .string_length_o   (string_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one word, optionally after an idle burst, and hold it until accepted.
  task automatic send_word(logic cmd, logic [ugtm_pkg::BYTE_W-1:0] idx,
                           logic [ugtm_pkg::CP_W-1:0] cp,
                           logic [ugtm_pkg::BYTE_W-1:0] tile,
                           logic [ugtm_pkg::BYTE_W-1:0] b);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= cmd;
    entry_index_i      <= idx;
    entry_code_point_i <= cp;
    entry_tile_i       <= tile;
    text_byte_i        <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(cmd, idx, cp, tile, b);
    if (cmd == ugtm_pkg::CMD_LOAD) slot_written[idx] = 1'b1;
  endtask

  // Entry fields carry garbage on text words; the block must ignore them.
  task automatic send_text(logic [ugtm_pkg::BYTE_W-1:0] b);
    send_word(ugtm_pkg::CMD_TEXT, 8'($urandom), 16'($urandom), 8'($urandom), b);
  endtask

  task automatic send_load(logic [ugtm_pkg::BYTE_W-1:0] idx, logic [ugtm_pkg::CP_W-1:0] cp,
                           logic [ugtm_pkg::BYTE_W-1:0] t);
    send_word(ugtm_pkg::CMD_LOAD, idx, cp, t, 8'($urandom));
  endtask

  task automatic send_cp3(logic [ugtm_pkg::CP_W-1:0] cp);
    send_text(8'hE0 | 8'(cp[15:12]));
    send_text(8'h80 | 8'(cp[11:6]));
    send_text(8'h80 | 8'(cp[5:0]));
  endtask

  // Drain the block, then write all four registers back to back.
  task automatic apply_settings(int size, int mlen, int fb, int term);
    ugtm_pkg::cfg_reg_e              regs [4];
    logic [ugtm_pkg::CFG_DATA_W-1:0] vals [4];
    regs = '{ugtm_pkg::CFG_TABLE_SIZE, ugtm_pkg::CFG_MAX_LEN, ugtm_pkg::CFG_FALLBACK,
             ugtm_pkg::CFG_TERMINATOR};
    vals = '{ugtm_pkg::CFG_DATA_W'(size), ugtm_pkg::CFG_DATA_W'(mlen),
             ugtm_pkg::CFG_DATA_W'(fb), ugtm_pkg::CFG_DATA_W'(term)};
    in_valid_i <= 1'b0;
    while (sb.expected_glyphs.size() != 0) @(posedge clk_i);
    // a trailing load or search may still be inside the block
    repeat (20) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    cur_size = (size > DEPTH) ? DEPTH : size;
  endtask

  // One stretch of random text: mostly well-formed sequences, some noise and broken ones.
  task automatic feed_phase(int count, int nul_one_in, bit ascii_heavy, int hold_at);
    int sent;
    int r;
    logic [ugtm_pkg::CP_W-1:0] cp;
    sent = 0;
    while (sent < count) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_req = 1'b1;
        hold_at  = -1;
      end
      r = $urandom_range(0, 99);
      if (nul_one_in != 0 && $urandom_range(1, nul_one_in) == 1) begin
        send_text('0);
        sent++;
      end else if (ascii_heavy ? (r < 85) : (r < 25)) begin
        send_text(8'($urandom_range(1, 127)));
        sent++;
      end else if (r < 33) begin
        send_load(8'($urandom), 16'($urandom), 8'($urandom));
        sent++;
      end else if (r < 58) begin
        // aim at a stored key so the search can hit
        cp = (cur_size != 0) ? sb.key_mem[$urandom_range(0, cur_size - 1)] : 16'($urandom);
        send_cp3(cp);
        sent += 3;
      end else if (r < 72) begin
        send_text(ugtm_pkg::LEAD2_CODE | 8'($urandom_range(0, 31)));
        send_text(8'h80 | 8'($urandom_range(0, 63)));
        sent += 2;
      end else if (r < 82) begin
        send_cp3(16'($urandom));
        sent += 3;
      end else if (r < 90) begin
        // lead followed by any byte, NUL included
        if ($urandom_range(0, 1) == 0)
          send_text(ugtm_pkg::LEAD2_CODE | 8'($urandom_range(0, 31)));
        else
          send_text(ugtm_pkg::LEAD3_CODE | 8'($urandom_range(0, 15)));
        send_text(8'($urandom_range(0, 255)));
        sent += 2;
      end else begin
        send_text(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // Receiver: random stall bursts, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 299) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check every accepted output word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(tile_o, is_terminator_o, string_length_o);
  end

  initial begin
    logic [ugtm_pkg::BYTE_W-1:0] plain_bytes [];
    logic [ugtm_pkg::BYTE_W-1:0] seq_bytes [];
    int n;
    int step;
    int size;
    int pre;
    int mlen;
    plain_bytes = '{8'h41, 8'h7F, 8'hC3, 8'hA9, 8'h80, 8'hF0, 8'hFF, 8'h00};
    // hit, hit, sequence refused at the limit then stray continuations, terminator,
    // key zero, NUL inside a sequence
    seq_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF, 8'h00,
                  8'hE0, 8'h80, 8'h80, 8'hC3, 8'h00};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, empty table: ASCII passes, a sequence gives the fallback,
    // a stray continuation and long leads drop.
    foreach (plain_bytes[i]) send_text(plain_bytes[i]);

    send_load(8'd0, 16'h0000, 8'h00);
    send_load(8'd1, 16'h00E9, 8'h11);
    send_load(8'd2, 16'h20AC, 8'h22);
    send_load(8'd3, 16'hFFFF, 8'hFF);
    apply_settings(4, 3, 0, 0);
    foreach (seq_bytes[i]) send_text(seq_bytes[i]);

    for (int p = 0; p < 10; p++) begin
      // no idling in some phases and in the last part of the run
      idle_pct = (p >= 8 || p % 3 == 2) ? 0 : $urandom_range(10, 40);

      // load a sorted table (phase 4: random keys), full depth once
      n    = (p == 1) ? DEPTH : $urandom_range(0, 12);
      step = (n == 0) ? 0 : 65536 / n;
      for (int i = 0; i < n; i++)
        send_load(8'(i), (p == 4) ? 16'($urandom) : 16'(i * step + $urandom_range(0, step - 1)),
                  8'($urandom));

      pre = 0;
      while (pre < DEPTH && slot_written[pre]) pre++;
      if (p == 1) size = DEPTH;
      else if (p == 6) size = 511;
      else if ($urandom_range(0, 3) == 0) size = $urandom_range(0, pre);
      else size = n;

      case ($urandom_range(0, 6))
        0:       mlen = 0;
        1:       mlen = 1;
        2:       mlen = 2;
        3:       mlen = $urandom_range(3, 12);
        4:       mlen = 255;
        default: mlen = $urandom_range(13, 80);
      endcase
      if (p == 7) mlen = 255;

      apply_settings(size, mlen,
                     (p == 3) ? 255 : (p == 5) ? 0 : $urandom_range(0, 255),
                     (p == 3) ? 0 : (p == 5) ? 255 : $urandom_range(0, 255));

      // phase 7 runs one long string into the string length limit
      feed_phase((p == 7) ? 320 : 70, (p == 7) ? 0 : $urandom_range(6, 25), p == 7,
                 (p == 3) ? 40 : -1);
    end

    idle_pct = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_glyphs.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_glyphs.size() == 0)
      $display("utf8_glyph_tile_mapper verification clean");
    else
      $display("utf8_glyph_tile_mapper verification failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("utf8_glyph_tile_mapper verification failed");
    $finish;
  end

endmodule
